/* hw/rtl/imrsz_pkg.sv */
// imrsz_pkg: shared widths, codes and types of the image resize block
// no dependencies; used by every module of the block except imrsz_ram
`timescale 1ns / 1ps

package imrsz_pkg;

   localparam int DEF_MAX_HEIGHT   = 128;
   localparam int DEF_MAX_WIDTH    = 128;
   localparam int DEF_MAX_CHANNELS = 4;
   localparam int DEF_FRAC_BITS    = 16;

   localparam int ROW_W      = 12;
   localparam int COL_W      = 12;
   localparam int CHAN_W     = 2;
   localparam int PIX_W      = 8;
   localparam int ISZ_W      = 8;
   localparam int OSZ_W      = 13;
   localparam int NCH_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int DIV_W      = OSZ_W + 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIZE_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_MAP  = 3'd6;

   // effective configuration, input sizes and channel count already clamped
   typedef struct packed {
      logic [ISZ_W-1:0] in_h;
      logic [ISZ_W-1:0] in_w;
      logic [OSZ_W-1:0] out_h;
      logic [OSZ_W-1:0] out_w;
      logic [NCH_W-1:0] nch;
      logic             bilinear;
      logic             corners;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAN_W-1:0] chan;
      logic [PIX_W-1:0]  pixel;
      logic              bad;
      logic              wr_ok;
   } item_type;

endpackage

/* hw/rtl/image_resize_nearest_bilinear.sv */
// image_resize_nearest_bilinear: top level, configuration registers and pipeline
// depends on imrsz_pkg, imrsz_map, imrsz_fetch, imrsz_blend, imrsz_ram
//
// Usage:
//   csr_*  : register writes (index 0..6: in_height, in_width, out_height,
//            out_width, channels, resize_mode, corner_map); always ready;
//            write only while no transaction is in flight.
//   req_*  : one transaction per cycle. cmd write stores a pixel byte at
//            (row, col, chan); cmd read asks for one output sample.
//   rsp_*  : one result per read transaction, in request order; writes give
//            none.
//   Throughput is one transaction per cycle while the output is not stalled.
//   The pipeline has one decode stage, one divider stage per quotient bit
//   (8 + FRAC_BITS), index mapping, the ram read, and two blend stages.
//   Reset clears the pipeline and sets the registers to their defaults; the
//   frame store is not cleared, and a pixel must be written before it is read.
//   When rsp_ready is low, results hold and the pipeline keeps accepting
//   until its empty stages are filled; req_ready then drops.
`timescale 1ns / 1ps

module image_resize_nearest_bilinear #(
   parameter int MAX_HEIGHT   = imrsz_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = imrsz_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = imrsz_pkg::DEF_MAX_CHANNELS,
   parameter int FRAC_BITS    = imrsz_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [imrsz_pkg::ROW_W-1:0]      req_row,
   input  logic [imrsz_pkg::COL_W-1:0]      req_col,
   input  logic [imrsz_pkg::CHAN_W-1:0]     req_chan,
   input  logic [imrsz_pkg::PIX_W-1:0]      req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [imrsz_pkg::PIX_W-1:0]      rsp_sample_value,
   output logic [imrsz_pkg::ROW_W-1:0]      rsp_out_row,
   output logic [imrsz_pkg::COL_W-1:0]      rsp_out_col,
   output logic [imrsz_pkg::CHAN_W-1:0]     rsp_out_chan,
   output logic                             rsp_bad_request,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [imrsz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imrsz_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW = imrsz_pkg::ISZ_W + FRAC_BITS;

   logic [imrsz_pkg::ISZ_W-1:0] in_height_ff, in_width_ff;
   logic [imrsz_pkg::OSZ_W-1:0] out_height_ff, out_width_ff;
   logic [imrsz_pkg::NCH_W-1:0] channels_ff;
   logic                        resize_mode_ff, corner_map_ff;
   imrsz_pkg::cfg_type          cfg;
   imrsz_pkg::item_type         req_item;

   logic                        map_valid, map_ready;
   imrsz_pkg::item_type         map_item;
   logic [QW-1:0]               map_qy, map_qx;
   logic                        fch_valid, fch_ready;
   imrsz_pkg::item_type         fch_item;
   logic [imrsz_pkg::PIX_W-1:0] fch_tl, fch_tr, fch_bl, fch_br;
   logic [FRAC_BITS-1:0]        fch_fx, fch_fy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff   <= imrsz_pkg::ISZ_W'(1);
         in_width_ff    <= imrsz_pkg::ISZ_W'(1);
         out_height_ff  <= imrsz_pkg::OSZ_W'(1);
         out_width_ff   <= imrsz_pkg::OSZ_W'(1);
         channels_ff    <= imrsz_pkg::NCH_W'(1);
         resize_mode_ff <= 1'b0;
         corner_map_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            imrsz_pkg::CSR_IN_HEIGHT:   in_height_ff   <= csr_wdata[imrsz_pkg::ISZ_W-1:0];
            imrsz_pkg::CSR_IN_WIDTH:    in_width_ff    <= csr_wdata[imrsz_pkg::ISZ_W-1:0];
            imrsz_pkg::CSR_OUT_HEIGHT:  out_height_ff  <= csr_wdata;
            imrsz_pkg::CSR_OUT_WIDTH:   out_width_ff   <= csr_wdata;
            imrsz_pkg::CSR_CHANNELS:    channels_ff    <= csr_wdata[imrsz_pkg::NCH_W-1:0];
            imrsz_pkg::CSR_RESIZE_MODE: resize_mode_ff <= csr_wdata[0];
            imrsz_pkg::CSR_CORNER_MAP:  corner_map_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input sizes of zero act as one; input sizes and channel count above the store saturate
   always_comb begin
      cfg.in_h = (in_height_ff == '0) ? imrsz_pkg::ISZ_W'(1)
               : (int'(in_height_ff) > MAX_HEIGHT) ? imrsz_pkg::ISZ_W'(MAX_HEIGHT)
               : in_height_ff;
      cfg.in_w = (in_width_ff == '0) ? imrsz_pkg::ISZ_W'(1)
               : (int'(in_width_ff) > MAX_WIDTH) ? imrsz_pkg::ISZ_W'(MAX_WIDTH)
               : in_width_ff;
      cfg.nch  = (int'(channels_ff) > MAX_CHANNELS) ? imrsz_pkg::NCH_W'(MAX_CHANNELS)
               : channels_ff;
      cfg.out_h    = out_height_ff;
      cfg.out_w    = out_width_ff;
      cfg.bilinear = resize_mode_ff;
      cfg.corners  = corner_map_ff;
   end

   always_comb begin
      req_item.cmd   = req_cmd;
      req_item.row   = req_row;
      req_item.col   = req_col;
      req_item.chan  = req_chan;
      req_item.pixel = req_pixel;
      req_item.bad   = 1'b0;
      req_item.wr_ok = 1'b0;
   end

   imrsz_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_item  (map_item),
      .out_qy    (map_qy),
      .out_qx    (map_qx)
   );

   imrsz_fetch #(
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .in_item   (map_item),
      .in_qy     (map_qy),
      .in_qx     (map_qx),
      .out_valid (fch_valid),
      .out_ready (fch_ready),
      .out_item  (fch_item),
      .out_tl    (fch_tl),
      .out_tr    (fch_tr),
      .out_bl    (fch_bl),
      .out_br    (fch_br),
      .out_fx    (fch_fx),
      .out_fy    (fch_fy)
   );

   imrsz_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (fch_valid),
      .in_ready         (fch_ready),
      .in_item          (fch_item),
      .in_tl            (fch_tl),
      .in_tr            (fch_tr),
      .in_bl            (fch_bl),
      .in_br            (fch_br),
      .in_fx            (fch_fx),
      .in_fy            (fch_fy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_chan     (rsp_out_chan),
      .rsp_bad_request  (rsp_bad_request)
   );

   // the pipeline only backs up behind a held result
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request side stalled without an output stall");

endmodule

/* hw/rtl/imrsz_ram.sv */
// imrsz_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module imrsz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/imrsz_map.sv */
// imrsz_map: request decode and pipelined source coordinate division
// depends on imrsz_pkg
`timescale 1ns / 1ps

module imrsz_map #(
   parameter int FRAC_BITS = imrsz_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imrsz_pkg::cfg_type                    cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  imrsz_pkg::item_type                   in_item,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output imrsz_pkg::item_type                   out_item,
   output logic [imrsz_pkg::ISZ_W+FRAC_BITS-1:0] out_qy,
   output logic [imrsz_pkg::ISZ_W+FRAC_BITS-1:0] out_qx
);

   localparam int QW = imrsz_pkg::ISZ_W + FRAC_BITS;
   localparam int DW = imrsz_pkg::DIV_W;
   localparam int PW = imrsz_pkg::ROW_W + 1 + imrsz_pkg::ISZ_W;
   localparam int IW = imrsz_pkg::ISZ_W;

   function automatic logic [imrsz_pkg::NCH_W-1:0] NCH_EXT(
      input logic [imrsz_pkg::CHAN_W-1:0] c);
      return imrsz_pkg::NCH_W'(c);
   endfunction

   logic                corners;
   logic [DW-1:0]       div_y, div_x;
   logic [PW-1:0]       num_y, num_x;
   logic                bad, wr_ok;
   imrsz_pkg::item_type item_in;

   logic                v_ff    [0:QW];
   logic                load    [0:QW];
   imrsz_pkg::item_type item_ff [0:QW];
   logic [DW-1:0]       remy_ff [0:QW];
   logic [DW-1:0]       remx_ff [0:QW];
   logic [QW-1:0]       nqy_ff  [0:QW];
   logic [QW-1:0]       nqx_ff  [0:QW];

   assign corners = cfg.bilinear & cfg.corners;

   // half-pixel: ((2o+1)*I*ONE) / (2O); corners: (o*(I-1)*ONE) / (O-1)
   always_comb begin
      if (corners) begin
         div_y = {1'b0, cfg.out_h - 1'b1};
         div_x = {1'b0, cfg.out_w - 1'b1};
         num_y = PW'(in_item.row) * PW'(cfg.in_h - 1'b1);
         num_x = PW'(in_item.col) * PW'(cfg.in_w - 1'b1);
      end else begin
         div_y = {cfg.out_h, 1'b0};
         div_x = {cfg.out_w, 1'b0};
         num_y = PW'({in_item.row, 1'b1}) * PW'(cfg.in_h);
         num_x = PW'({in_item.col, 1'b1}) * PW'(cfg.in_w);
      end
   end

   always_comb begin
      bad = ({1'b0, in_item.row} >= cfg.out_h) || ({1'b0, in_item.col} >= cfg.out_w)
            || (NCH_EXT(in_item.chan) >= cfg.nch);
      wr_ok = (in_item.row < {4'b0, cfg.in_h}) && (in_item.col < {4'b0, cfg.in_w})
              && (NCH_EXT(in_item.chan) < cfg.nch);
      item_in       = in_item;
      item_in.bad   = bad;
      item_in.wr_ok = wr_ok;
   end

   assign load[QW] = !v_ff[QW] | out_ready;
   assign load[0]  = !v_ff[0] | load[1];
   assign in_ready = load[0];

   // stage 0: numerator split, top bits form the starting remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (load[0]) begin
         v_ff[0] <= in_valid;
      end
      if (load[0]) begin
         item_ff[0] <= item_in;
         remy_ff[0] <= DW'(num_y[PW-1:IW]);
         remx_ff[0] <= DW'(num_x[PW-1:IW]);
         nqy_ff[0]  <= {num_y[IW-1:0], {FRAC_BITS{1'b0}}};
         nqx_ff[0]  <= {num_x[IW-1:0], {FRAC_BITS{1'b0}}};
      end
   end

   // one quotient bit per stage and axis
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [DW:0]   ty, tx;
      logic          gey, gex;
      logic [DW-1:0] remy_in, remx_in;

      if (k < QW) begin : g_ld
         assign load[k] = !v_ff[k] | load[k+1];
      end

      always_comb begin
         ty  = {remy_ff[k-1], nqy_ff[k-1][QW-1]};
         tx  = {remx_ff[k-1], nqx_ff[k-1][QW-1]};
         gey = ty >= {1'b0, div_y};
         gex = tx >= {1'b0, div_x};
         remy_in = gey ? DW'(ty - {1'b0, div_y}) : DW'(ty);
         remx_in = gex ? DW'(tx - {1'b0, div_x}) : DW'(tx);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (load[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (load[k]) begin
            item_ff[k] <= item_ff[k-1];
            remy_ff[k] <= remy_in;
            remx_ff[k] <= remx_in;
            nqy_ff[k]  <= {nqy_ff[k-1][QW-2:0], gey};
            nqx_ff[k]  <= {nqx_ff[k-1][QW-2:0], gex};
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_item  = item_ff[QW];
   // zero divisor in corner mode maps to coordinate 0
   assign out_qy = (corners && cfg.out_h == imrsz_pkg::OSZ_W'(1)) ? '0 : nqy_ff[QW];
   assign out_qx = (corners && cfg.out_w == imrsz_pkg::OSZ_W'(1)) ? '0 : nqx_ff[QW];

endmodule

/* hw/rtl/imrsz_fetch.sv */
// imrsz_fetch: neighbour index mapping and four parity-banked frame store rams
// depends on imrsz_pkg and imrsz_ram
`timescale 1ns / 1ps

module imrsz_fetch #(
   parameter int MAX_HEIGHT   = imrsz_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = imrsz_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = imrsz_pkg::DEF_MAX_CHANNELS,
   parameter int FRAC_BITS    = imrsz_pkg::DEF_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imrsz_pkg::cfg_type                    cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  imrsz_pkg::item_type                   in_item,
   input  logic [imrsz_pkg::ISZ_W+FRAC_BITS-1:0] in_qy,
   input  logic [imrsz_pkg::ISZ_W+FRAC_BITS-1:0] in_qx,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output imrsz_pkg::item_type                   out_item,
   output logic [imrsz_pkg::PIX_W-1:0]           out_tl,
   output logic [imrsz_pkg::PIX_W-1:0]           out_tr,
   output logic [imrsz_pkg::PIX_W-1:0]           out_bl,
   output logic [imrsz_pkg::PIX_W-1:0]           out_br,
   output logic [FRAC_BITS-1:0]                  out_fx,
   output logic [FRAC_BITS-1:0]                  out_fy
);

   localparam int QW     = imrsz_pkg::ISZ_W + FRAC_BITS;
   localparam int IW     = imrsz_pkg::ISZ_W;
   localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
   localparam int HALF_W = (MAX_WIDTH + 1) / 2;
   localparam int DEPTH  = HALF_H * HALF_W * MAX_CHANNELS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [IW-1:0]        lo;
      logic [IW-1:0]        hi;
      logic [FRAC_BITS-1:0] f;
   } axis_type;

   // parity bits of lo/hi per axis, picks the bank for each neighbour
   typedef struct packed {
      logic ylo;
      logic yhi;
      logic xlo;
      logic xhi;
   } sel_type;

   function automatic axis_type map_axis(input logic [QW-1:0] q, input logic [IW-1:0] isz,
                                         input logic bilinear, input logic corners);
      axis_type             a;
      logic [IW-1:0]        last;
      logic [IW-1:0]        near;
      logic [QW-1:0]        qb;
      logic [IW-1:0]        r0;
      logic [FRAC_BITS-1:0] f0;
      last = isz - 1'b1;
      near = (q < HALF) ? '0 : q[QW-1:FRAC_BITS];
      qb   = (corners || q >= HALF) ? (corners ? q : q - HALF) : '0;
      r0   = qb[QW-1:FRAC_BITS];
      f0   = qb[FRAC_BITS-1:0];
      if (!bilinear) begin
         a.lo = (near > last) ? last : near;
         a.hi = a.lo;
         a.f  = '0;
      end else begin
         if (r0 >= last) begin
            a.lo = last;
            a.f  = (r0 == last) ? f0 : '0;
         end else begin
            a.lo = r0;
            a.f  = f0;
         end
         a.hi = (a.lo < last) ? a.lo + 1'b1 : a.lo;
      end
      return a;
   endfunction

   axis_type ay, ax;
   sel_type  sel_in;
   logic [AW-1:0]                addr_in [0:3];
   logic [3:0]                   wbank_in;

   logic                         f1_v_ff;
   imrsz_pkg::item_type          f1_item_ff;
   logic [AW-1:0]                f1_addr_ff [0:3];
   logic [3:0]                   f1_wbank_ff;
   sel_type                      f1_sel_ff;
   logic [FRAC_BITS-1:0]         f1_fx_ff, f1_fy_ff;

   logic                         m_v_ff;
   imrsz_pkg::item_type          m_item_ff;
   sel_type                      m_sel_ff;
   logic [FRAC_BITS-1:0]         m_fx_ff, m_fy_ff;
   logic [imrsz_pkg::PIX_W-1:0]  rdata [0:3];
   logic                         load_f1, load_m;
   logic [3:0]                   bank_we;
   logic                         bank_en;

   always_comb begin
      if (in_item.cmd == imrsz_pkg::CMD_WRITE) begin
         ay.lo = in_item.row[IW-1:0];
         ay.hi = in_item.row[IW-1:0];
         ay.f  = '0;
         ax.lo = in_item.col[IW-1:0];
         ax.hi = in_item.col[IW-1:0];
         ax.f  = '0;
      end else begin
         ay = map_axis(in_qy, cfg.in_h, cfg.bilinear, cfg.corners);
         ax = map_axis(in_qx, cfg.in_w, cfg.bilinear, cfg.corners);
      end
      sel_in.ylo = ay.lo[0];
      sel_in.yhi = ay.hi[0];
      sel_in.xlo = ax.lo[0];
      sel_in.xhi = ax.hi[0];
   end

   // bank index is {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_addr
      localparam logic PY = 1'((b >> 1) & 1);
      localparam logic PX = 1'(b & 1);
      logic [IW-1:0] r, c;
      always_comb begin
         r = (ay.lo[0] == PY) ? ay.lo : ay.hi;
         c = (ax.lo[0] == PX) ? ax.lo : ax.hi;
         addr_in[b] = AW'((AW'(r[IW-1:1]) * AW'(HALF_W) + AW'(c[IW-1:1])) * AW'(MAX_CHANNELS)
                          + AW'(in_item.chan));
         wbank_in[b] = (in_item.cmd == imrsz_pkg::CMD_WRITE) && in_item.wr_ok
                       && (in_item.row[0] == PY) && (in_item.col[0] == PX);
      end
   end

   assign load_m   = !m_v_ff | out_ready;
   assign load_f1  = !f1_v_ff | load_m;
   assign in_ready = load_f1;
   assign bank_en  = load_m & f1_v_ff;
   assign bank_we  = bank_en ? f1_wbank_ff : 4'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         m_v_ff  <= 1'b0;
      end else begin
         if (load_f1) begin
            f1_v_ff <= in_valid;
         end
         if (load_m) begin
            m_v_ff <= f1_v_ff;
         end
      end
      if (load_f1) begin
         f1_item_ff  <= in_item;
         f1_addr_ff  <= addr_in;
         f1_wbank_ff <= wbank_in;
         f1_sel_ff   <= sel_in;
         f1_fx_ff    <= ax.f;
         f1_fy_ff    <= ay.f;
      end
      if (load_m) begin
         m_item_ff <= f1_item_ff;
         m_sel_ff  <= f1_sel_ff;
         m_fx_ff   <= f1_fx_ff;
         m_fy_ff   <= f1_fy_ff;
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      imrsz_ram #(
         .WIDTH (imrsz_pkg::PIX_W),
         .DEPTH (DEPTH),
         .AW    (AW)
      ) u_ram (
         .clock (clock),
         .en    (bank_en),
         .we    (bank_we[b]),
         .addr  (f1_addr_ff[b]),
         .wdata (f1_item_ff.pixel),
         .rdata (rdata[b])
      );
   end

   assign out_valid = m_v_ff;
   assign out_item  = m_item_ff;
   assign out_tl    = rdata[{m_sel_ff.ylo, m_sel_ff.xlo}];
   assign out_tr    = rdata[{m_sel_ff.ylo, m_sel_ff.xhi}];
   assign out_bl    = rdata[{m_sel_ff.yhi, m_sel_ff.xlo}];
   assign out_br    = rdata[{m_sel_ff.yhi, m_sel_ff.xhi}];
   assign out_fx    = m_fx_ff;
   assign out_fy    = m_fy_ff;

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one bank written in a cycle");

   a_write_only_for_writes: assert property (@(posedge clock) disable iff (reset)
      (bank_we != 4'b0) |-> (f1_item_ff.cmd == imrsz_pkg::CMD_WRITE && f1_item_ff.wr_ok))
      else $error("bank written by a read transaction");

endmodule

/* hw/rtl/imrsz_blend.sv */
// imrsz_blend: two-stage bilinear weighting and the result register
// depends on imrsz_pkg
`timescale 1ns / 1ps

module imrsz_blend #(
   parameter int FRAC_BITS = imrsz_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  imrsz_pkg::item_type           in_item,
   input  logic [imrsz_pkg::PIX_W-1:0]   in_tl,
   input  logic [imrsz_pkg::PIX_W-1:0]   in_tr,
   input  logic [imrsz_pkg::PIX_W-1:0]   in_bl,
   input  logic [imrsz_pkg::PIX_W-1:0]   in_br,
   input  logic [FRAC_BITS-1:0]          in_fx,
   input  logic [FRAC_BITS-1:0]          in_fy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [imrsz_pkg::PIX_W-1:0]   rsp_sample_value,
   output logic [imrsz_pkg::ROW_W-1:0]   rsp_out_row,
   output logic [imrsz_pkg::COL_W-1:0]   rsp_out_col,
   output logic [imrsz_pkg::CHAN_W-1:0]  rsp_out_chan,
   output logic                          rsp_bad_request
);

   localparam int WW = FRAC_BITS + 1;
   localparam int HW = FRAC_BITS + imrsz_pkg::PIX_W;
   localparam int SW = 2 * FRAC_BITS + imrsz_pkg::PIX_W + 1;
   localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

   logic [WW-1:0]               wx0, wy0;
   logic [HW:0]                 top_in, bot_in;
   logic [SW-1:0]               sum;
   logic                        b1_v_ff, out_v_ff, load_b1, load_out;
   imrsz_pkg::item_type         b1_item_ff;
   logic [HW-1:0]               top_ff, bot_ff;
   logic [FRAC_BITS-1:0]        b1_fy_ff;
   logic [imrsz_pkg::PIX_W-1:0] value_ff;
   logic [imrsz_pkg::ROW_W-1:0] row_ff;
   logic [imrsz_pkg::COL_W-1:0] col_ff;
   logic [imrsz_pkg::CHAN_W-1:0] chan_ff;
   logic                        bad_ff;

   // horizontal blend of both neighbour rows, then vertical
   always_comb begin
      wx0    = ONE - WW'(in_fx);
      top_in = (HW+1)'(wx0) * (HW+1)'(in_tl) + (HW+1)'(in_fx) * (HW+1)'(in_tr);
      bot_in = (HW+1)'(wx0) * (HW+1)'(in_bl) + (HW+1)'(in_fx) * (HW+1)'(in_br);
      wy0    = ONE - WW'(b1_fy_ff);
      sum    = SW'(wy0) * SW'(top_ff) + SW'(b1_fy_ff) * SW'(bot_ff);
   end

   assign load_out = !out_v_ff | rsp_ready;
   assign load_b1  = !b1_v_ff | load_out;
   assign in_ready = load_b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (load_b1) begin
            b1_v_ff <= in_valid;
         end
         if (load_out) begin
            // write transactions end here without a result
            out_v_ff <= b1_v_ff && (b1_item_ff.cmd == imrsz_pkg::CMD_READ);
         end
      end
      if (load_b1) begin
         b1_item_ff <= in_item;
         top_ff     <= top_in[HW-1:0];
         bot_ff     <= bot_in[HW-1:0];
         b1_fy_ff   <= in_fy;
      end
      if (load_out) begin
         value_ff <= b1_item_ff.bad ? '0 : sum[2*FRAC_BITS +: imrsz_pkg::PIX_W];
         row_ff   <= b1_item_ff.row;
         col_ff   <= b1_item_ff.col;
         chan_ff  <= b1_item_ff.chan;
         bad_ff   <= b1_item_ff.bad;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_sample_value = value_ff;
   assign rsp_out_row      = row_ff;
   assign rsp_out_col      = col_ff;
   assign rsp_out_chan     = chan_ff;
   assign rsp_bad_request  = bad_ff;

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |-> (rsp_sample_value == '0))
      else $error("bad request with nonzero sample");

endmodule

/* test/testbench.sv */
// testbench: self-checking bench for image_resize_nearest_bilinear (nearest and bilinear)
// depends on imrsz_pkg and the block's rtl; a scoreboard class predicts every read result
`timescale 1ns / 1ps

class resize_scoreboard;
   localparam int MAX_H  = 128;
   localparam int MAX_W  = 128;
   localparam int MAX_CH = 4;
   localparam int FRAC   = 16;

   bit [7:0]  frame_copy [MAX_H*MAX_W*MAX_CH];
   bit [7:0]  in_h, in_w;
   bit [12:0] out_h, out_w;
   bit [2:0]  nch;
   bit        bilinear, corners;
   int        fails;

   // expected results, oldest first
   bit [7:0]  exp_value [$];
   bit [11:0] exp_row [$];
   bit [11:0] exp_col [$];
   bit [1:0]  exp_chan [$];
   bit        exp_bad [$];

   function new();
      in_h = 1; in_w = 1; out_h = 1; out_w = 1; nch = 1;
      bilinear = 0; corners = 0; fails = 0;
   endfunction

   function int eff_h();
      return (in_h == 0) ? 1 : ((in_h > MAX_H) ? MAX_H : in_h);
   endfunction

   function int eff_w();
      return (in_w == 0) ? 1 : ((in_w > MAX_W) ? MAX_W : in_w);
   endfunction

   function int eff_ch();
      return (nch > MAX_CH) ? MAX_CH : nch;
   endfunction

   function int pending();
      return exp_value.size();
   endfunction

   function void set_reg(bit [2:0] idx, bit [12:0] data);
      case (idx)
         imrsz_pkg::CSR_IN_HEIGHT:   in_h = data[7:0];
         imrsz_pkg::CSR_IN_WIDTH:    in_w = data[7:0];
         imrsz_pkg::CSR_OUT_HEIGHT:  out_h = data;
         imrsz_pkg::CSR_OUT_WIDTH:   out_w = data;
         imrsz_pkg::CSR_CHANNELS:    nch = data[2:0];
         imrsz_pkg::CSR_RESIZE_MODE: bilinear = data[0];
         imrsz_pkg::CSR_CORNER_MAP:  corners = data[0];
         default: ;
      endcase
   endfunction

   function longint unsigned src_pos(longint unsigned o, longint unsigned isz,
                                     longint unsigned osz, bit by_corners);
      longint unsigned one, v;
      one = 64'd1 << FRAC;
      if (by_corners) begin
         if (osz <= 1) return 0;
         return (o * (isz - 1) * one) / (osz - 1);
      end
      v = ((2 * o + 1) * isz * one) / (2 * osz);
      return (v < one / 2) ? 0 : v - one / 2;
   endfunction

   function longint unsigned pix(longint unsigned r, longint unsigned c, bit [1:0] ch);
      return frame_copy[(r * MAX_W + c) * MAX_CH + ch];
   endfunction

   function bit [7:0] resample(bit [11:0] row, bit [11:0] col, bit [1:0] ch);
      longint unsigned ih, iw, one, qy, qx, y, x, yr, xr, fy, fx, yp, xp, top, bot, acc;
      ih = eff_h(); iw = eff_w(); one = 64'd1 << FRAC;
      if (!bilinear) begin
         qy = src_pos(row, ih, out_h, 0);
         qx = src_pos(col, iw, out_w, 0);
         y = (qy + one / 2) >> FRAC;
         x = (qx + one / 2) >> FRAC;
         if (y > ih - 1) y = ih - 1;
         if (x > iw - 1) x = iw - 1;
         return pix(y, x, ch);
      end
      qy = src_pos(row, ih, out_h, corners);
      qx = src_pos(col, iw, out_w, corners);
      yr = qy >> FRAC; xr = qx >> FRAC;
      fy = qy & (one - 1); fx = qx & (one - 1);
      // past the last index the fraction only survives on the last index itself
      if (yr >= ih - 1) begin
         yr = ih - 1;
         if (yr != (qy >> FRAC)) fy = 0;
      end
      if (xr >= iw - 1) begin
         xr = iw - 1;
         if (xr != (qx >> FRAC)) fx = 0;
      end
      yp = (yr < ih - 1) ? yr + 1 : yr;
      xp = (xr < iw - 1) ? xr + 1 : xr;
      top = (one - fx) * pix(yr, xr, ch) + fx * pix(yr, xp, ch);
      bot = (one - fx) * pix(yp, xr, ch) + fx * pix(yp, xp, ch);
      acc = ((one - fy) * top + fy * bot) >> (2 * FRAC);
      return (acc > 255) ? 8'd255 : acc[7:0];
   endfunction

   function void note_item(bit cmd, bit [11:0] row, bit [11:0] col, bit [1:0] ch,
                           bit [7:0] pixel);
      bit bad;
      if (cmd == imrsz_pkg::CMD_WRITE) begin
         if (row < eff_h() && col < eff_w() && ch < eff_ch())
            frame_copy[(row * MAX_W + col) * MAX_CH + ch] = pixel;
         return;
      end
      bad = (row >= out_h || col >= out_w || ch >= eff_ch());
      exp_value.push_back(bad ? 8'd0 : resample(row, col, ch));
      exp_row.push_back(row);
      exp_col.push_back(col);
      exp_chan.push_back(ch);
      exp_bad.push_back(bad);
   endfunction

   function void check_result(bit [7:0] value, bit [11:0] row, bit [11:0] col,
                              bit [1:0] ch, bit bad);
      bit [7:0]  e_value;
      bit [11:0] e_row, e_col;
      bit [1:0]  e_chan;
      bit        e_bad;
      if (exp_value.size() == 0) begin
         $error("result with no read outstanding: row %0d col %0d", row, col);
         fails++;
         return;
      end
      e_value = exp_value.pop_front();
      e_row = exp_row.pop_front();
      e_col = exp_col.pop_front();
      e_chan = exp_chan.pop_front();
      e_bad = exp_bad.pop_front();
      if (value !== e_value) begin
         $error("sample_value: expected %0d, got %0d", e_value, value); fails++;
      end
      if (row !== e_row) begin
         $error("out_row: expected %0d, got %0d", e_row, row); fails++;
      end
      if (col !== e_col) begin
         $error("out_col: expected %0d, got %0d", e_col, col); fails++;
      end
      if (ch !== e_chan) begin
         $error("out_chan: expected %0d, got %0d", e_chan, ch); fails++;
      end
      if (bad !== e_bad) begin
         $error("bad_request: expected %0d, got %0d", e_bad, bad); fails++;
      end
   endfunction
endclass

module testbench;

   localparam int SETTLE = 40;
   localparam longint CYCLE_LIMIT = 3000000;
   // an index with no register behind it
   localparam bit [2:0] CSR_UNKNOWN = 3'd7;

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_ready;
   logic                                req_cmd = imrsz_pkg::CMD_WRITE;
   logic [imrsz_pkg::ROW_W-1:0]         req_row = '0;
   logic [imrsz_pkg::COL_W-1:0]         req_col = '0;
   logic [imrsz_pkg::CHAN_W-1:0]        req_chan = '0;
   logic [imrsz_pkg::PIX_W-1:0]         req_pixel = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 0;
   logic [imrsz_pkg::PIX_W-1:0]         rsp_sample_value;
   logic [imrsz_pkg::ROW_W-1:0]         rsp_out_row;
   logic [imrsz_pkg::COL_W-1:0]         rsp_out_col;
   logic [imrsz_pkg::CHAN_W-1:0]        rsp_out_chan;
   logic                                rsp_bad_request;
   logic                                csr_valid = 0;
   logic                                csr_ready;
   logic [imrsz_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [imrsz_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   resize_scoreboard board = new();
   longint cycles = 0;
   int     rsp_stall = 0;
   bit     req_busy = 0;
   bit     rsp_busy = 0;

   image_resize_nearest_bilinear DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // result side: sample at the rising edge, draw the next stall per transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_sample_value, rsp_out_row, rsp_out_col, rsp_out_chan,
                            rsp_bad_request);
         rsp_stall = rsp_busy ? 0 : $urandom_range(0, 11);
      end else if (rsp_stall > 0) begin
         rsp_stall--;
      end
   end

   always @(negedge clock) begin
      rsp_ready = (rsp_stall == 0);
   end

   task automatic send(bit cmd, bit [11:0] row, bit [11:0] col, bit [1:0] ch,
                       bit [7:0] pixel);
      int gap;
      gap = req_busy ? 0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clock);
      req_valid = 1; req_cmd = cmd; req_row = row; req_col = col;
      req_chan = ch; req_pixel = pixel;
      do @(posedge clock); while (!req_ready);
      board.note_item(cmd, row, col, ch, pixel);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_reg(bit [2:0] idx, bit [12:0] data);
      csr_valid = 1; csr_index = idx; csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(int ih, int iw, int oh, int ow, int nc, bit bl, bit ac);
      drain();
      write_reg(imrsz_pkg::CSR_IN_HEIGHT, 13'(ih));
      write_reg(imrsz_pkg::CSR_IN_WIDTH, 13'(iw));
      write_reg(imrsz_pkg::CSR_OUT_HEIGHT, 13'(oh));
      write_reg(imrsz_pkg::CSR_OUT_WIDTH, 13'(ow));
      write_reg(imrsz_pkg::CSR_CHANNELS, 13'(nc));
      write_reg(imrsz_pkg::CSR_RESIZE_MODE, 13'(bl));
      write_reg(imrsz_pkg::CSR_CORNER_MAP, 13'(ac));
      write_reg(CSR_UNKNOWN, 13'($urandom));
   endtask

   // store every in-range entry, with some ignored writes mixed in
   task automatic fill_image();
      for (int r = 0; r < board.eff_h(); r++)
         for (int c = 0; c < board.eff_w(); c++)
            for (int ch = 0; ch < board.eff_ch(); ch++) begin
               if ($urandom_range(0, 15) == 0)
                  send(imrsz_pkg::CMD_WRITE,
                       12'(board.eff_h() + $urandom_range(0, 4095 - board.eff_h())),
                       12'($urandom), 2'($urandom), 8'($urandom));
               send(imrsz_pkg::CMD_WRITE, 12'(r), 12'(c), 2'(ch), 8'($urandom));
            end
      if (board.eff_ch() < 4)
         send(imrsz_pkg::CMD_WRITE, 12'd0, 12'd0, 2'd3, 8'hff);
      send(imrsz_pkg::CMD_WRITE, 12'd0, 12'd4095, 2'd0, 8'h00);
   endtask

   task automatic edge_reads();
      int oh, ow;
      oh = board.out_h; ow = board.out_w;
      send(imrsz_pkg::CMD_READ, 12'd0, 12'd0, 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'(oh - 1), 12'(ow - 1), 2'(board.eff_ch() - 1), 8'hff);
      send(imrsz_pkg::CMD_READ, 12'(oh - 1), 12'd0, 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd0, 12'(ow - 1), 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd4095, 12'd4095, 2'd3, 8'hff);
      send(imrsz_pkg::CMD_READ, 12'(oh), 12'd0, 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd0, 12'(ow), 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd0, 12'd0, 2'd3, 8'd0);
   endtask

   task automatic random_reads(int count);
      bit [11:0] row, col;
      bit [1:0]  ch;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            req_busy = ($urandom_range(0, 3) == 0);
            rsp_busy = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 9) == 0) begin
            row = 12'($urandom); col = 12'($urandom); ch = 2'($urandom);
         end else begin
            row = 12'($urandom_range(0, board.out_h - 1));
            col = 12'($urandom_range(0, board.out_w - 1));
            ch = (board.eff_ch() == 0) ? 2'($urandom)
                                       : 2'($urandom_range(0, board.eff_ch() - 1));
         end
         send(imrsz_pkg::CMD_READ, row, col, ch, 8'($urandom));
      end
   endtask

   task automatic run_phase(int ih, int iw, int oh, int ow, int nc, bit bl, bit ac,
                            int count);
      configure(ih, iw, oh, ow, nc, bl, ac);
      fill_image();
      edge_reads();
      random_reads(count);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // defaults after reset
      fill_image();
      send(imrsz_pkg::CMD_READ, 12'd0, 12'd0, 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd1, 12'd0, 2'd0, 8'd0);
      send(imrsz_pkg::CMD_READ, 12'd0, 12'd0, 2'd1, 8'd0);

      run_phase(4, 5, 9, 7, 3, 1, 0, 30);
      run_phase(4, 5, 9, 7, 3, 1, 1, 30);
      run_phase(3, 6, 2, 3, 4, 0, 0, 30);
      run_phase(0, 255, 1, 4096, 1, 1, 1, 40);
      run_phase(128, 1, 4096, 1, 1, 0, 0, 40);
      run_phase(128, 2, 4096, 3, 1, 1, 0, 30);
      run_phase(2, 2, 1, 1, 0, 1, 0, 20);
      run_phase(2, 3, 7, 5, 6, 1, 1, 30);
      for (int p = 0; p < 6; p++)
         run_phase($urandom_range(1, 6), $urandom_range(1, 6),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(1, 20),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4096)
                                               : $urandom_range(1, 20),
                   $urandom_range(1, 4), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 30);

      drain();
      if (board.fails == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
